### rtl/wsd_pkg.sv
// shared types and codes for the wire segment distance block
package wsd_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_DIR_X       = 3'd3,
    REG_DIR_Y       = 3'd4,
    REG_DIR_Z       = 3'd5,
    REG_HALF_LENGTH = 3'd6
  } cfg_reg_t;

  // result classification
  typedef enum logic [1:0] {
    CASE_PARALLEL   = 2'd0,
    CASE_SKEW       = 2'd1,
    CASE_ENDPOINT   = 2'd2,
    CASE_DEGENERATE = 2'd3
  } case_code_t;

  // per-item flags carried down the front pipeline
  typedef struct packed {
    logic par;
    logic degen;
    logic vz_nz;
  } side_t;

endpackage

### rtl/wsd_mul.sv
// two-stage signed multiplier built from registered 33x33 limb products
module wsd_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  localparam int LIMB_W = 32;
  localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
  localparam int EA = NA * LIMB_W;
  localparam int EB = NB * LIMB_W;
  localparam int PW = AW + BW;

  logic signed [EA-1:0]         a_ext;
  logic signed [EB-1:0]         b_ext;
  logic signed [2*LIMB_W+1:0]   pp_r [NA][NB];
  logic signed [PW-1:0]         sum_nxt;
  logic signed [PW-1:0]         p_r;

  assign a_ext = EA'(a);
  assign b_ext = EB'(b);

  // lower limbs unsigned, top limb carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_row
    for (genvar j = 0; j < NB; j++) begin : g_col
      logic signed [LIMB_W:0] la;
      logic signed [LIMB_W:0] lb;
      assign la = (i == NA - 1) ? {a_ext[EA-1], a_ext[i*LIMB_W +: LIMB_W]}
                                : {1'b0, a_ext[i*LIMB_W +: LIMB_W]};
      assign lb = (j == NB - 1) ? {b_ext[EB-1], b_ext[j*LIMB_W +: LIMB_W]}
                                : {1'b0, b_ext[j*LIMB_W +: LIMB_W]};
      always_ff @(posedge clk) begin
        pp_r[i][j] <= la * lb;
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_nxt = sum_nxt + (PW'(pp_r[i][j]) <<< ((i + j) * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= sum_nxt;
  end

  assign p = p_r;

endmodule

### rtl/wsd_dot3.sv
// three-term signed dot product: wsd_mul products summed into a register
module wsd_dot3 #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a [3],
  input  logic signed [BW-1:0]    b [3],
  output logic signed [AW+BW+1:0] dot
);
  localparam int PW = AW + BW;

  logic signed [PW-1:0]   prod [3];
  logic signed [PW+1:0]   dot_r;

  for (genvar k = 0; k < 3; k++) begin : g_term
    wsd_mul #(.AW(AW), .BW(BW)) u_mul (
      .clk (clk),
      .a   (a[k]),
      .b   (b[k]),
      .p   (prod[k])
    );
  end

  always_ff @(posedge clk) begin
    dot_r <= (PW+2)'(prod[0]) + (PW+2)'(prod[1]) + (PW+2)'(prod[2]);
  end

  assign dot = dot_r;

endmodule

### rtl/wsd_root.sv
// pipelined root of a ratio: largest q with q*q*den <= num, one bit per stage
module wsd_root #(
  parameter int NW = 136,
  parameter int DW = 64,
  parameter int QW = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [NW-1:0]       num,
  input  logic [DW-1:0]       den,
  input  wsd_pkg::case_code_t in_code,
  output logic                out_vld,
  output logic [QW-1:0]       root,
  output wsd_pkg::case_code_t out_code
);
  import wsd_pkg::*;

  // rem = num - q*q*den, acc = q*den; NW must cover 2*QW+DW bits
  logic [NW-1:0]  rem_r  [QW];
  logic [NW-1:0]  acc_r  [QW];
  logic [DW-1:0]  den_r  [QW];
  logic [QW-1:0]  q_r    [QW];
  case_code_t     code_r [QW];
  logic [QW-1:0]  vld_r;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] acc_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    case_code_t    code_in;
    logic          vld_in;
    logic [NW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = num;
      assign acc_in  = '0;
      assign den_in  = den;
      assign q_in    = '0;
      assign code_in = in_code;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign acc_in  = acc_r[k-1];
      assign den_in  = den_r[k-1];
      assign q_in    = q_r[k-1];
      assign code_in = code_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // (q + 2^B)^2 * den - q^2 * den
    assign trial = (acc_in << (B + 1)) + (NW'(den_in) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? rem_in - trial : rem_in;
      acc_r[k]  <= take ? acc_in + (NW'(den_in) << B) : acc_in;
      q_r[k]    <= take ? (q_in | (QW'(1) << B)) : q_in;
      den_r[k]  <= den_in;
      code_r[k] <= code_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign root     = q_r[QW-1];
  assign out_code = code_r[QW-1];

endmodule

### rtl/wire_segment_distance.sv
// top level: distance between a configured reference wire and a stream of wires
//
// usage
//   configuration: write the reference wire through cfg_valid/cfg_ready with
//   cfg_index selecting the register (center x/y/z, direction x/y/z, half
//   length) and cfg_data carrying the word; cfg_ready is always high. write
//   only while no item is in flight.
//   input: one wire word per cycle, taken at each rising edge with start high;
//   busy is always low, so a new word may follow every cycle.
//   output: out_valid strobes for one cycle with out_wire_distance,
//   out_case_code and out_saturated; the receiver cannot stall, so the block
//   never has to hold a result back.
//   throughput: one word per cycle. the pipeline is a ten stage front end
//   (difference, cross products, dot products, wide products, case select),
//   a 33 stage root extractor that resolves one result bit per stage and an
//   output register.
//   reset: synchronous, active low; empties the pipeline and loads the
//   reference wire with zero center, zero length, direction +z.
module wire_segment_distance (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_other_center_x,
  input  logic signed [31:0] in_other_center_y,
  input  logic signed [31:0] in_other_center_z,
  input  logic signed [15:0] in_other_dir_x,
  input  logic signed [15:0] in_other_dir_y,
  input  logic signed [15:0] in_other_dir_z,
  input  logic [23:0]        in_other_half_length,
  // result channel
  output logic               out_valid,
  output logic [31:0]        out_wire_distance,
  output logic [1:0]         out_case_code,
  output logic               out_saturated,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import wsd_pkg::*;

  localparam int NUM_W    = 136;
  localparam int DEN_W    = 64;
  localparam int ROOT_W   = 33;
  localparam int FRONT_N  = 10;
  localparam int PIPE_LAT = FRONT_N + ROOT_W + 1;

  // reference wire registers
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic signed [15:0] ux_r, uy_r, uz_r;
  logic [23:0]        h_r;

  logic signed [31:0] c_vec [3];
  logic signed [31:0] d_vec [3];
  logic signed [15:0] u_vec [3];
  logic signed [15:0] vin_vec [3];
  logic signed [24:0] h_s;
  logic               accept;

  // front pipeline
  logic [FRONT_N-1:0] vld_r;
  logic signed [32:0] w0_r [3];
  logic signed [15:0] v0_r [3];
  logic [23:0]        g0_r;
  logic signed [32:0] n1_r [3];
  logic signed [49:0] x1_r [3];
  logic signed [40:0] hu1_r [3];
  logic signed [40:0] gv1_r [3];
  logic signed [32:0] w1_r [3];
  logic signed [15:0] v1_r [3];
  logic [23:0]        g1_r;
  logic signed [49:0] r2_r [3];
  logic signed [49:0] p2_r [3];
  logic signed [32:0] n2_r [3];
  logic signed [49:0] x2_r [3];
  logic signed [15:0] v2_r [3];
  logic [23:0]        g2_r, g3_r, g4_r, g5_r;
  side_t              side_nxt;
  side_t              side_r [7];

  // dot products, valid at the fifth stage
  logic signed [67:0]  nn5, ur5, vr5;
  logic signed [84:0]  rn5;
  logic signed [101:0] rr5, pp5, xx5;
  logic signed [33:0]  uu5, vv5, uv5;

  // wide products, valid at the seventh stage
  logic signed [101:0] a1_7, a2_7, b1_7, b2_7;
  logic signed [169:0] rn2_7;
  logic signed [93:0]  lims_7, limt_7;
  logic signed [25:0]  two_h, two_g;

  logic signed [101:0] smin6_r, smin7_r, smin8_r;
  logic signed [67:0]  nn6_r, nn7_r, nn8_r;
  logic signed [33:0]  vv6_r, vv7_r, vv8_r;
  logic signed [101:0] xx6_r, xx7_r, xx8_r;
  logic signed [102:0] ns8_r, nt8_r;
  logic signed [93:0]  lims8_r, limt8_r;
  logic signed [169:0] rn2_8_r;

  // case select
  logic               outside;
  logic [NUM_W-1:0]   num_nxt, num9_r;
  logic [DEN_W-1:0]   den_nxt, den9_r;
  case_code_t         code_nxt, code9_r;

  // root and output
  logic               root_vld;
  logic [ROOT_W-1:0]  root_q;
  case_code_t         root_code;
  logic               out_valid_r;
  logic [31:0]        dist_r;
  case_code_t         code_r;
  logic               sat_r;

  function automatic logic signed [32:0] cross16(input logic signed [15:0] a1,
                                                 input logic signed [15:0] b2,
                                                 input logic signed [15:0] a2,
                                                 input logic signed [15:0] b1);
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    t1 = a1 * b2;
    t2 = a2 * b1;
    return 33'(t1) - 33'(t2);
  endfunction

  function automatic logic signed [49:0] cross_w(input logic signed [32:0] w1,
                                                 input logic signed [15:0] v2,
                                                 input logic signed [32:0] w2,
                                                 input logic signed [15:0] v1);
    logic signed [48:0] t1;
    logic signed [48:0] t2;
    t1 = w1 * v2;
    t2 = w2 * v1;
    return 50'(t1) - 50'(t2);
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign c_vec[0]   = cx_r;
  assign c_vec[1]   = cy_r;
  assign c_vec[2]   = cz_r;
  assign u_vec[0]   = ux_r;
  assign u_vec[1]   = uy_r;
  assign u_vec[2]   = uz_r;
  assign d_vec[0]   = in_other_center_x;
  assign d_vec[1]   = in_other_center_y;
  assign d_vec[2]   = in_other_center_z;
  assign vin_vec[0] = in_other_dir_x;
  assign vin_vec[1] = in_other_dir_y;
  assign vin_vec[2] = in_other_dir_z;
  assign h_s        = $signed({1'b0, h_r});

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
      ux_r <= '0;
      uy_r <= '0;
      uz_r <= 16'sd32767;
      h_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:    cx_r <= cfg_data;
        REG_CENTER_Y:    cy_r <= cfg_data;
        REG_CENTER_Z:    cz_r <= cfg_data;
        REG_DIR_X:       ux_r <= cfg_data[15:0];
        REG_DIR_Y:       uy_r <= cfg_data[15:0];
        REG_DIR_Z:       uz_r <= cfg_data[15:0];
        REG_HALF_LENGTH: h_r  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // valid bits of the front pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_N-2:0], accept};
    end
  end

  // stage 0: center offset w = c - d
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      w0_r[k] <= 33'(c_vec[k]) - 33'(d_vec[k]);
      v0_r[k] <= vin_vec[k];
    end
    g0_r <= in_other_half_length;
  end

  // stage 1: direction cross product, w x v, length-scaled directions
  always_ff @(posedge clk) begin
    n1_r[0] <= cross16(u_vec[1], v0_r[2], u_vec[2], v0_r[1]);
    n1_r[1] <= cross16(u_vec[2], v0_r[0], u_vec[0], v0_r[2]);
    n1_r[2] <= cross16(u_vec[0], v0_r[1], u_vec[1], v0_r[0]);
    x1_r[0] <= cross_w(w0_r[1], v0_r[2], w0_r[2], v0_r[1]);
    x1_r[1] <= cross_w(w0_r[2], v0_r[0], w0_r[0], v0_r[2]);
    x1_r[2] <= cross_w(w0_r[0], v0_r[1], w0_r[1], v0_r[0]);
    for (int k = 0; k < 3; k++) begin
      hu1_r[k] <= h_s * u_vec[k];
      gv1_r[k] <= $signed({1'b0, g0_r}) * v0_r[k];
      w1_r[k]  <= w0_r[k];
      v1_r[k]  <= v0_r[k];
    end
    g1_r <= g0_r;
  end

  // classification flags
  always_comb begin
    side_nxt.par   = (n1_r[0] == '0) && (n1_r[1] == '0) && (n1_r[2] == '0);
    side_nxt.vz_nz = (v1_r[2] != '0);
    if (side_nxt.par) begin
      side_nxt.degen = (g1_r == '0) ||
                       ((v1_r[0] == '0) && (v1_r[1] == '0) && (v1_r[2] == '0));
    end else begin
      side_nxt.degen = (h_r == '0) || (g1_r == '0);
    end
  end

  // stage 2: minus-end and plus-end offsets in 2^-15 micrometre
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      r2_r[k] <= (50'(w1_r[k]) <<< 15) - 50'(hu1_r[k]) + 50'(gv1_r[k]);
      p2_r[k] <= (50'(w1_r[k]) <<< 15) + 50'(hu1_r[k]) - 50'(gv1_r[k]);
      n2_r[k] <= n1_r[k];
      x2_r[k] <= x1_r[k];
      v2_r[k] <= v1_r[k];
    end
    g2_r      <= g1_r;
    side_r[0] <= side_nxt;
    for (int k = 1; k < 7; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // stages 3 to 5: dot products
  wsd_dot3 #(.AW(33), .BW(33)) u_dot_nn (.clk(clk), .a(n2_r),  .b(n2_r),  .dot(nn5));
  wsd_dot3 #(.AW(50), .BW(33)) u_dot_rn (.clk(clk), .a(r2_r),  .b(n2_r),  .dot(rn5));
  wsd_dot3 #(.AW(50), .BW(50)) u_dot_rr (.clk(clk), .a(r2_r),  .b(r2_r),  .dot(rr5));
  wsd_dot3 #(.AW(50), .BW(50)) u_dot_pp (.clk(clk), .a(p2_r),  .b(p2_r),  .dot(pp5));
  wsd_dot3 #(.AW(50), .BW(50)) u_dot_xx (.clk(clk), .a(x2_r),  .b(x2_r),  .dot(xx5));
  wsd_dot3 #(.AW(16), .BW(50)) u_dot_ur (.clk(clk), .a(u_vec), .b(r2_r),  .dot(ur5));
  wsd_dot3 #(.AW(16), .BW(50)) u_dot_vr (.clk(clk), .a(v2_r),  .b(r2_r),  .dot(vr5));
  wsd_dot3 #(.AW(16), .BW(16)) u_dot_uu (.clk(clk), .a(u_vec), .b(u_vec), .dot(uu5));
  wsd_dot3 #(.AW(16), .BW(16)) u_dot_vv (.clk(clk), .a(v2_r),  .b(v2_r),  .dot(vv5));
  wsd_dot3 #(.AW(16), .BW(16)) u_dot_uv (.clk(clk), .a(u_vec), .b(v2_r),  .dot(uv5));

  always_ff @(posedge clk) begin
    g3_r <= g2_r;
    g4_r <= g3_r;
    g5_r <= g4_r;
  end

  // stages 6 and 7: closest-point numerators, squared rn, segment limits
  // the closest-point denominator uu*vv - uv*uv equals nn exactly
  assign two_h = $signed({1'b0, h_r, 1'b0});
  assign two_g = $signed({1'b0, g5_r, 1'b0});

  wsd_mul #(.AW(34), .BW(68)) u_mul_a1  (.clk(clk), .a(uv5), .b(vr5), .p(a1_7));
  wsd_mul #(.AW(34), .BW(68)) u_mul_a2  (.clk(clk), .a(vv5), .b(ur5), .p(a2_7));
  wsd_mul #(.AW(34), .BW(68)) u_mul_b1  (.clk(clk), .a(uu5), .b(vr5), .p(b1_7));
  wsd_mul #(.AW(34), .BW(68)) u_mul_b2  (.clk(clk), .a(uv5), .b(ur5), .p(b2_7));
  wsd_mul #(.AW(85), .BW(85)) u_mul_rn2 (.clk(clk), .a(rn5), .b(rn5), .p(rn2_7));
  wsd_mul #(.AW(68), .BW(26)) u_mul_ls  (.clk(clk), .a(nn5), .b(two_h), .p(lims_7));
  wsd_mul #(.AW(68), .BW(26)) u_mul_lt  (.clk(clk), .a(nn5), .b(two_g), .p(limt_7));

  always_ff @(posedge clk) begin
    // nearer pair of same-side endpoints
    smin6_r <= (rr5 < pp5) ? rr5 : pp5;
    smin7_r <= smin6_r;
    smin8_r <= smin7_r;
    nn6_r   <= nn5;
    nn7_r   <= nn6_r;
    nn8_r   <= nn7_r;
    vv6_r   <= vv5;
    vv7_r   <= vv6_r;
    vv8_r   <= vv7_r;
    xx6_r   <= xx5;
    xx7_r   <= xx6_r;
    xx8_r   <= xx7_r;
    ns8_r   <= 103'(a1_7) - 103'(a2_7);
    nt8_r   <= 103'(b1_7) - 103'(b2_7);
    lims8_r <= lims_7;
    limt8_r <= limt_7;
    rn2_8_r <= rn2_7;
  end

  // stage 9: pick the root operands for the case at hand
  always_comb begin
    outside = ((uz_r != '0) && ((ns8_r < 0) || (ns8_r > 103'(lims8_r)))) ||
              (side_r[6].vz_nz && ((nt8_r < 0) || (nt8_r > 103'(limt8_r))));
    priority if (side_r[6].degen) begin
      num_nxt  = '0;
      den_nxt  = '0;
      code_nxt = CASE_DEGENERATE;
    end else if (side_r[6].par) begin
      // point-to-line distance: |w x v|^2 / |v|^2
      num_nxt  = NUM_W'(xx8_r[100:0]);
      den_nxt  = DEN_W'(vv8_r[32:0]);
      code_nxt = CASE_PARALLEL;
    end else if (outside) begin
      num_nxt  = NUM_W'(smin8_r[100:30]);
      den_nxt  = DEN_W'(1);
      code_nxt = CASE_ENDPOINT;
    end else begin
      // common perpendicular: (r.n)^2 / (|n|^2 * 2^30)
      num_nxt  = rn2_8_r[NUM_W+29:30];
      den_nxt  = nn8_r[DEN_W-1:0];
      code_nxt = CASE_SKEW;
    end
  end

  always_ff @(posedge clk) begin
    num9_r  <= num_nxt;
    den9_r  <= den_nxt;
    code9_r <= code_nxt;
  end

  // stages 10 to 42: one root bit per stage
  wsd_root #(.NW(NUM_W), .DW(DEN_W), .QW(ROOT_W)) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_r[FRONT_N-1]),
    .num      (num9_r),
    .den      (den9_r),
    .in_code  (code9_r),
    .out_vld  (root_vld),
    .root     (root_q),
    .out_code (root_code)
  );

  // output register with saturation at 32 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= root_vld;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= root_code;
    if (root_code == CASE_DEGENERATE) begin
      dist_r <= '0;
      sat_r  <= 1'b0;
    end else begin
      dist_r <= root_q[ROOT_W-1] ? '1 : root_q[31:0];
      sat_r  <= root_q[ROOT_W-1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wire_distance = dist_r;
  assign out_case_code     = code_r;
  assign out_saturated     = sat_r;

  // every accepted word gives exactly one strobe a fixed time later
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("accepted word produced no result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_LAT))
    else $error("result without an accepted word");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_case_code == CASE_DEGENERATE)) |->
      ((out_wire_distance == '0) && !out_saturated))
    else $error("degenerate result carries a distance");

endmodule
